### rtl/core/assert_macros.svh
// assertion macros shared by the rtl core
// each macro expects clk and rst_n in scope of the module that uses it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define XWCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define XWCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/xwcs_pkg.sv
// shared types, character codes and phase sequencing for the xml minifier
// no dependencies
package xwcs_pkg;

    localparam int BLANK_DEPTH_DEF = 32;

    localparam logic ACT_TEXT = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // controller phases, in emission order
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_SPACE,
        ST_FLUSH,
        ST_BYTE,
        ST_END
    } state_t;

    typedef enum logic [2:0] {
        SRC_PREFIX,
        SRC_SPACE,
        SRC_RAM,
        SRC_HELD,
        SRC_INPUT,
        SRC_END
    } src_t;

    // what one accepted item has to emit
    typedef struct packed {
        logic [1:0] prefix_n;
        logic       space;
        logic       flush;
        logic       store;
        logic       byte_out;
        logic       end_out;
        logic       err;
    } plan_t;

    typedef struct packed {
        logic accept;
        logic emit;
        src_t src;
        logic last;
        logic flush_start;
        logic flush_step;
        logic flush_done;
        logic pre_step;
    } cmd_t;

    typedef struct packed {
        plan_t plan_now;
        plan_t plan;
        logic  slot_free;
        logic  pre_last;
        logic  flush_more;
    } status_t;

    function automatic logic blank_byte(logic [7:0] b);
        return b inside {CH_SP, CH_TAB, CH_LF, CH_CR};
    endfunction

    // first phase after cur that the plan still needs, idle if none
    function automatic state_t next_phase(state_t cur, plan_t p);
        state_t r;
        r = ST_IDLE;
        if (cur < ST_END && p.end_out)
            r = ST_END;
        if (cur < ST_BYTE && p.byte_out)
            r = ST_BYTE;
        if (cur < ST_FLUSH && p.flush)
            r = ST_FLUSH;
        if (cur < ST_SPACE && p.space)
            r = ST_SPACE;
        if (cur < ST_PREFIX && p.prefix_n != 2'd0)
            r = ST_PREFIX;
        return r;
    endfunction

endpackage

### rtl/core/xwcs_ram.sv
// generic single write port ram with registered read
// no dependencies
module xwcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/xwcs_ctrl.sv
// phase sequencer of the xml minifier
// depends on xwcs_pkg and assert_macros.svh
`include "assert_macros.svh"

module xwcs_ctrl
    import xwcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_t nxt;
        logic   done;
        nxt        = ST_IDLE;
        done       = 1'b0;
        cmd        = '0;
        cmd.src    = SRC_END;
        state_next = state_reg;
        item_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    nxt = next_phase(ST_IDLE, status.plan_now);
                    // single plain byte goes straight to the output
                    if (nxt == ST_BYTE && next_phase(ST_BYTE, status.plan_now) == ST_IDLE
                        && status.slot_free)
                    begin
                        cmd.emit = 1'b1;
                        cmd.src  = SRC_INPUT;
                        cmd.last = 1'b1;
                    end
                    else
                    begin
                        state_next      = nxt;
                        cmd.flush_start = (nxt == ST_FLUSH);
                    end
                end
            end
            ST_PREFIX:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_PREFIX;
                    if (status.pre_last)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        cmd.pre_step = 1'b1;
                    end
                end
            end
            ST_SPACE:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_SPACE;
                    done     = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_RAM;
                    if (status.flush_more)
                    begin
                        cmd.flush_step = 1'b1;
                    end
                    else
                    begin
                        cmd.flush_done = 1'b1;
                        done = 1'b1;
                    end
                end
            end
            ST_BYTE:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_HELD;
                    done     = 1'b1;
                end
            end
            ST_END:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_END;
                    done     = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (done)
        begin
            nxt             = next_phase(state_reg, status.plan);
            state_next      = nxt;
            cmd.last        = (nxt == ST_IDLE);
            cmd.flush_start = (nxt == ST_FLUSH);
        end
    end

    `XWCS_ASSERT_IMP(a_emit_slot, cmd.emit, status.slot_free, "emit into a full output slot")
    `XWCS_ASSERT_NXT(a_end_idle, (state_reg == ST_END) && cmd.emit, state_reg == ST_IDLE,
                     "end result not followed by idle")

endmodule

### rtl/core/xwcs_dp.sv
// scanner state, blank store and output register of the xml minifier
// depends on xwcs_pkg, xwcs_ram and assert_macros.svh
`include "assert_macros.svh"

module xwcs_dp
    import xwcs_pkg::*;
#(
    parameter int BLANK_DEPTH = BLANK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       action,
    input  logic [7:0] text_byte,
    input  cmd_t       cmd,
    output status_t    status,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       end_mark,
    output logic       comment_error,
    output logic       last,
    output logic       result_valid,
    input  logic       result_stall
);

    localparam int IW = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;
    localparam int CW = $clog2(BLANK_DEPTH + 1);

    logic          tag_reg, tag_next;
    logic          quote_reg, quote_next;
    logic          pend_reg, pend_next;
    logic [1:0]    held_reg, held_next;
    logic          comm_reg, comm_next;
    logic [1:0]    dash_reg, dash_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg;
    logic [1:0]    pre_reg;
    plan_t         plan_reg, plan_now;
    logic [7:0]    hold_byte_reg;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          byte_valid_reg;
    logic          end_mark_reg;
    logic          comment_error_reg;
    logic          last_reg;

    logic          store_wr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // decode one item against the scanner state
    always_comb
    begin
        logic [7:0] b;
        logic       tag_path;
        b          = text_byte;
        tag_path   = 1'b0;
        plan_now   = '0;
        store_wr   = 1'b0;
        tag_next   = tag_reg;
        quote_next = quote_reg;
        pend_next  = pend_reg;
        held_next  = held_reg;
        comm_next  = comm_reg;
        dash_next  = dash_reg;
        count_next = count_reg;
        if (action == ACT_END)
        begin
            plan_now.err      = comm_reg;
            plan_now.prefix_n = held_reg;
            plan_now.space    = (held_reg == 2'd0) && tag_reg && !quote_reg && pend_reg;
            plan_now.flush    = (count_reg != '0);
            plan_now.end_out  = 1'b1;
            tag_next   = 1'b0;
            quote_next = 1'b0;
            pend_next  = 1'b0;
            held_next  = 2'd0;
            comm_next  = 1'b0;
            dash_next  = 2'd0;
        end
        else if (comm_reg)
        begin
            if (b == CH_DASH)
            begin
                if (dash_reg != 2'd2)
                    dash_next = dash_reg + 2'd1;
            end
            else if (b == CH_GT && dash_reg == 2'd2)
            begin
                comm_next = 1'b0;
                dash_next = 2'd0;
            end
            else
            begin
                dash_next = 2'd0;
            end
        end
        else if (held_reg != 2'd0 && ((held_reg == 2'd1 && b == CH_BANG)
                 || (held_reg != 2'd1 && b == CH_DASH)))
        begin
            // opener continues
            if (held_reg == 2'd3)
            begin
                held_next = 2'd0;
                comm_next = 1'b1;
                dash_next = 2'd2;
            end
            else
            begin
                held_next = held_reg + 2'd1;
            end
        end
        else if (held_reg != 2'd0 || tag_reg)
        begin
            tag_path = 1'b1;
            if (held_reg != 2'd0)
            begin
                // prefix mismatch: held bytes open a tag
                plan_now.prefix_n = held_reg;
                held_next = 2'd0;
                tag_next  = 1'b1;
            end
        end
        else if (b == CH_LT)
        begin
            count_next = '0;
            held_next  = 2'd1;
        end
        else if (blank_byte(b))
        begin
            if (count_reg == CW'(BLANK_DEPTH))
            begin
                plan_now.flush = 1'b1;
                plan_now.store = 1'b1;
            end
            else
            begin
                store_wr   = 1'b1;
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            plan_now.flush    = (count_reg != '0);
            plan_now.byte_out = 1'b1;
        end

        if (tag_path)
        begin
            if (quote_reg)
            begin
                if (b == CH_QUOTE)
                    quote_next = 1'b0;
                plan_now.byte_out = 1'b1;
            end
            else if (blank_byte(b))
            begin
                pend_next = 1'b1;
            end
            else
            begin
                plan_now.space    = pend_reg && (b != CH_GT);
                plan_now.byte_out = 1'b1;
                pend_next         = 1'b0;
                if (b == CH_QUOTE)
                    quote_next = 1'b1;
                else if (b == CH_GT)
                    tag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= 1'b0;
            quote_reg <= 1'b0;
            pend_reg  <= 1'b0;
            held_reg  <= 2'd0;
            comm_reg  <= 1'b0;
            dash_reg  <= 2'd0;
            count_reg <= '0;
            ptr_reg   <= '0;
            pre_reg   <= 2'd0;
            plan_reg  <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                tag_reg   <= tag_next;
                quote_reg <= quote_next;
                pend_reg  <= pend_next;
                held_reg  <= held_next;
                comm_reg  <= comm_next;
                dash_reg  <= dash_next;
                count_reg <= count_next;
                plan_reg  <= plan_now;
            end
            else if (cmd.flush_done)
            begin
                count_reg <= plan_reg.store ? CW'(1) : CW'(0);
            end
            if (cmd.flush_start)
            begin
                ptr_reg <= CW'(1);
            end
            else if (cmd.flush_step)
            begin
                ptr_reg <= ptr_reg + CW'(1);
            end
            if (cmd.accept)
            begin
                pre_reg <= 2'd0;
            end
            else if (cmd.pre_step)
            begin
                pre_reg <= pre_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hold_byte_reg <= text_byte;
        end
    end

    // blank store: held blanks between tags
    assign wr_en   = (cmd.accept && store_wr) || (cmd.flush_done && plan_reg.store);
    assign wr_addr = cmd.flush_done ? IW'(0) : count_reg[IW-1:0];
    assign wr_data = cmd.flush_done ? hold_byte_reg : text_byte;
    assign rd_en   = cmd.flush_start || cmd.flush_step;
    assign rd_addr = cmd.flush_start ? IW'(0) : ptr_reg[IW-1:0];

    xwcs_ram #(
        .WIDTH (8),
        .DEPTH (BLANK_DEPTH)
    ) u_blank_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            last_reg          <= cmd.last;
            byte_valid_reg    <= 1'b1;
            end_mark_reg      <= 1'b0;
            comment_error_reg <= 1'b0;
            case (cmd.src)
                SRC_PREFIX:
                begin
                    out_byte_reg <= (pre_reg == 2'd0) ? CH_LT
                                  : (pre_reg == 2'd1) ? CH_BANG : CH_DASH;
                end
                SRC_SPACE: out_byte_reg <= CH_SP;
                SRC_RAM:   out_byte_reg <= rd_data;
                SRC_HELD:  out_byte_reg <= hold_byte_reg;
                SRC_INPUT: out_byte_reg <= text_byte;
                default:
                begin
                    out_byte_reg      <= 8'd0;
                    byte_valid_reg    <= 1'b0;
                    end_mark_reg      <= 1'b1;
                    comment_error_reg <= plan_reg.err;
                end
            endcase
        end
    end

    assign status.plan_now   = plan_now;
    assign status.plan       = plan_reg;
    assign status.slot_free  = !out_valid_reg || !result_stall;
    assign status.pre_last   = (pre_reg == (plan_reg.prefix_n - 2'd1));
    assign status.flush_more = (ptr_reg != count_reg);

    assign result_valid  = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign end_mark      = end_mark_reg;
    assign comment_error = comment_error_reg;
    assign last          = last_reg;

    `XWCS_ASSERT_IMP(a_step_in_range, cmd.flush_step, ptr_reg < count_reg,
                     "blank flush reads past the held count")
    `XWCS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(BLANK_DEPTH),
                     "blank count above store depth")

endmodule

### rtl/core/xml_whitespace_comment_stripper.sv
// top level of the streaming xml whitespace and comment minifier
// depends on xwcs_pkg, xwcs_ctrl, xwcs_dp (which holds xwcs_ram)

// Byte-serial XML minifier. Each item is a text byte (action 0) or an end of
// text (action 1); each result is one output byte or the end result, with
// last set on the final result an item causes. Comments are dropped, blank
// runs inside tags shrink to one space (none before '>'), quoted strings
// pass untouched, and blanks between tags are held in a BLANK_DEPTH entry
// store and dropped if '<' follows. While the output does not stall, a byte
// with at most one plain result is accepted and registered for output in the
// same cycle, so text runs at one byte per cycle, and any other item is
// accepted, then gives its results one per cycle: the held '<', '<!' or '<!-'
// prefix, a tag space, the held blanks (read from the blank store one per cycle
// through its registered read port), the byte and the end result. The blank
// store needs no clearing after reset: a fill count tracks what it holds.
module xml_whitespace_comment_stripper
    import xwcs_pkg::*;
#(
    parameter int BLANK_DEPTH = BLANK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // item channel
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       action,
    input  logic [7:0] text_byte,
    // result channel
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       end_mark,
    output logic       comment_error,
    output logic       last
);

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: one phase per kind of result, accepts only when idle
    xwcs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: scanner state, blank store and result register
    xwcs_dp #(
        .BLANK_DEPTH (BLANK_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .action        (action),
        .text_byte     (text_byte),
        .cmd           (cmd),
        .status        (status),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .end_mark      (end_mark),
        .comment_error (comment_error),
        .last          (last),
        .result_valid  (result_valid),
        .result_stall  (result_stall)
    );

endmodule
